// File: hdl/stream_segment_reassembly_tracker_assert.svh
// assertion macros for the segment reassembly tracker
`ifndef STREAM_SEGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`define STREAM_SEGMENT_REASSEMBLY_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define SSRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssrt check failed");
`define SSRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssrt check failed");
`else
`define SSRT_ASSERT_IMP(lbl, ante, cons)
`define SSRT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/ssrt_pkg.sv
// shared types and constants for the segment reassembly tracker
package ssrt_pkg;
  localparam int MAX_SEGMENTS = 8192;
  localparam int SEG_AW = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = 14;
  localparam int TOT_W = 36;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_RESEND = 2'd1,
    MODE_RUN    = 2'd2,
    MODE_LEADER = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MARK_EMPTY  = 2'd0,
    MARK_FILLED = 2'd1,
    MARK_ASKED  = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_ID_ZERO   = 3'd2,
    ST_ID_RANGE  = 3'd3,
    ST_SIZE      = 3'd4,
    ST_MAP_FAIL  = 3'd5,
    ST_BAD_RANGE = 3'd6
  } status_t;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISP, S_MUL1, S_MUL2, S_DIV0, S_DIV, S_BUILD,
    S_INS_RD, S_INS_CHK, S_RES, S_RUN_RD, S_RUN_CHK, S_DONE
  } state_t;
endpackage

// File: hdl/stream_segment_reassembly_tracker.sv
// segment reassembly tracker: per-segment marks in one memory, map builder, stats
// after reset a clearing pass over all 8192 mark entries runs before the first word is taken
// one word at a time: insert reads, checks and writes the mark, leader sets the flag, resend marks
// each segment of its range, empty run walks back over empty segments; the result is registered
// first insert after a map change builds the map (multiply, 36-step divide)
// and runs a clearing pass over all 8192 entries of the mark memory
`include "stream_segment_reassembly_tracker_assert.svh"
module stream_segment_reassembly_tracker
  import ssrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [23:0] in_packet_id,
  input  logic [23:0] in_stop_id,
  input  logic [15:0] in_segment_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [34:0] out_write_offset,
  output logic [15:0] out_write_length,
  output logic [13:0] out_empty_run,
  output logic [13:0] out_segments_empty,
  output logic [23:0] out_resend_requests,
  output logic [13:0] out_segment_count,
  output logic        out_leader_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [1:0] mark_mem [MAX_SEGMENTS];
  logic              mem_we;
  logic [SEG_AW-1:0] mem_waddr, mem_raddr;
  logic [1:0]        mem_wdata, mem_rdata_r;

  state_t state_r, state_nxt;
  logic [15:0] width_r, height_r;
  logic [6:0]  bpp_r;
  logic        map_valid_r, map_valid_nxt;
  logic [15:0] mapped_size_r, mapped_size_nxt, tail_size_r, tail_size_nxt;
  logic [CNT_W-1:0] map_count_r, map_count_nxt, empty_total_r, empty_total_nxt;
  logic [23:0] resend_total_r, resend_total_nxt;
  logic        leader_r, leader_nxt;
  logic        clr_ins_r, clr_ins_nxt;

  logic [1:0]  mode_r, mode_nxt;
  logic [23:0] id_r, id_nxt, stop_r, stop_nxt;
  logic [15:0] seg_r, seg_nxt;

  logic [SEG_AW-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0]  walk_r, walk_nxt, run_r, run_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [TOT_W-1:0]  quo_r, quo_nxt;
  logic [15:0]       rem_r, rem_nxt;
  logic [5:0]        div_cnt_r, div_cnt_nxt;
  logic [34:0]       woff_r, woff_nxt;
  logic [15:0]       wlen_r, wlen_nxt;
  status_t           status_r, status_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  o_status_r, o_status_nxt;
  logic [34:0] o_woff_r, o_woff_nxt;
  logic [15:0] o_wlen_r, o_wlen_nxt;
  logic [13:0] o_run_r, o_run_nxt, o_empty_r, o_empty_nxt, o_count_r, o_count_nxt;
  logic [23:0] o_resend_r, o_resend_nxt;
  logic        o_leader_r, o_leader_nxt;

  logic [16:0] trial;
  logic [36:0] cnt_full;
  logic [15:0] size_sel;
  logic [SEG_AW-1:0] idx;
  logic [CNT_W-1:0] cnt_eff;
  logic [23:0] range_len;
  logic [24:0] resend_sum;
  logic cfg_hit;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign idx = SEG_AW'(id_r - 24'd1);

  // mark memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mark_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mark_mem[mem_raddr];
  end

  // config registers; a changed value drops the map
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg_hit = (cfg_data != width_r);
        REG_HEIGHT: cfg_hit = (cfg_data != height_r);
        REG_BPP:    cfg_hit = (cfg_data[6:0] != bpp_r);
        default:    cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      bpp_r    <= 7'd8;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_r <= cfg_data;
      if (cfg_index == REG_BPP)    bpp_r    <= cfg_data[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      map_valid_r    <= 1'b0;
      mapped_size_r  <= '0;
      tail_size_r    <= '0;
      map_count_r    <= '0;
      empty_total_r  <= '0;
      resend_total_r <= '0;
      leader_r       <= 1'b0;
      clr_ins_r      <= 1'b0;
      addr_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      map_valid_r    <= map_valid_nxt & ~cfg_hit;
      mapped_size_r  <= mapped_size_nxt;
      tail_size_r    <= tail_size_nxt;
      map_count_r    <= map_count_nxt;
      empty_total_r  <= empty_total_nxt;
      resend_total_r <= resend_total_nxt;
      leader_r       <= leader_nxt;
      clr_ins_r      <= clr_ins_nxt;
      addr_r         <= addr_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    id_r       <= id_nxt;
    stop_r     <= stop_nxt;
    seg_r      <= seg_nxt;
    walk_r     <= walk_nxt;
    run_r      <= run_nxt;
    prod_r     <= prod_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    woff_r     <= woff_nxt;
    wlen_r     <= wlen_nxt;
    status_r   <= status_nxt;
    o_status_r <= o_status_nxt;
    o_woff_r   <= o_woff_nxt;
    o_wlen_r   <= o_wlen_nxt;
    o_run_r    <= o_run_nxt;
    o_empty_r  <= o_empty_nxt;
    o_count_r  <= o_count_nxt;
    o_resend_r <= o_resend_nxt;
    o_leader_r <= o_leader_nxt;
  end

  always_comb begin
    state_nxt        = state_r;
    map_valid_nxt    = map_valid_r;
    mapped_size_nxt  = mapped_size_r;
    tail_size_nxt    = tail_size_r;
    map_count_nxt    = map_count_r;
    empty_total_nxt  = empty_total_r;
    resend_total_nxt = resend_total_r;
    leader_nxt       = leader_r;
    clr_ins_nxt      = clr_ins_r;
    addr_nxt         = addr_r;
    mode_nxt         = mode_r;
    id_nxt           = id_r;
    stop_nxt         = stop_r;
    seg_nxt          = seg_r;
    walk_nxt         = walk_r;
    run_nxt          = run_r;
    prod_nxt         = prod_r;
    quo_nxt          = quo_r;
    rem_nxt          = rem_r;
    div_cnt_nxt      = div_cnt_r;
    woff_nxt         = woff_r;
    wlen_nxt         = wlen_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r & ~out_ready;
    o_status_nxt     = o_status_r;
    o_woff_nxt       = o_woff_r;
    o_wlen_nxt       = o_wlen_r;
    o_run_nxt        = o_run_r;
    o_empty_nxt      = o_empty_r;
    o_count_nxt      = o_count_r;
    o_resend_nxt     = o_resend_r;
    o_leader_nxt     = o_leader_r;
    mem_we           = 1'b0;
    mem_waddr        = addr_r;
    mem_wdata        = MARK_EMPTY;
    mem_raddr        = idx;
    trial            = {rem_r, quo_r[TOT_W-1]};
    cnt_full         = {1'b0, quo_r} + 37'(rem_r != 16'd0);
    size_sel         = ({1'b0, idx} == map_count_r - 14'd1) ? tail_size_r : mapped_size_r;
    cnt_eff          = map_valid_r ? map_count_r : '0;
    range_len        = stop_r - id_r + 24'd1;
    resend_sum       = {1'b0, resend_total_r} + {1'b0, range_len};

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = MARK_EMPTY;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == SEG_AW'(MAX_SEGMENTS - 1)) begin
          state_nxt   = clr_ins_r ? S_DISP : S_IDLE;
          clr_ins_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          id_nxt     = in_packet_id;
          stop_nxt   = in_stop_id;
          seg_nxt    = in_segment_bytes;
          status_nxt = ST_OK;
          woff_nxt   = '0;
          wlen_nxt   = '0;
          run_nxt    = '0;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        unique case (mode_r)
          MODE_INSERT: begin
            if (id_r == 24'd0) status_nxt = ST_ID_ZERO;
            else if (!map_valid_r) state_nxt = S_MUL1;
            else if (id_r > 24'(map_count_r)) status_nxt = ST_ID_RANGE;
            else state_nxt = S_INS_RD;
          end
          MODE_RESEND: begin
            if (!map_valid_r || id_r == 24'd0 || stop_r < id_r ||
                stop_r > 24'(map_count_r)) begin
              status_nxt = ST_BAD_RANGE;
            end else begin
              addr_nxt  = idx;
              state_nxt = S_RES;
            end
          end
          MODE_RUN: begin
            if (id_r >= 24'd2) begin
              if (25'(id_r) > 25'(cnt_eff) + 25'd1) begin
                status_nxt = ST_ID_RANGE;
              end else begin
                walk_nxt  = CNT_W'(id_r - 24'd1);
                state_nxt = S_RUN_RD;
              end
            end
          end
          MODE_LEADER: leader_nxt = 1'b1;
          default: ;
        endcase
      end
      S_MUL1: begin
        prod_nxt  = 32'(width_r) * 32'(height_r);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        quo_nxt   = TOT_W'((39'(prod_r) * 39'(bpp_r)) >> 3);
        state_nxt = S_DIV0;
      end
      S_DIV0: begin
        rem_nxt     = '0;
        div_cnt_nxt = '0;
        if (seg_r == 16'd0 || quo_r == '0) begin
          status_nxt = ST_MAP_FAIL;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (trial >= {1'b0, seg_r}) begin
          rem_nxt = 16'(trial - {1'b0, seg_r});
          quo_nxt = {quo_r[TOT_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[15:0];
          quo_nxt = {quo_r[TOT_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 6'd1;
        if (div_cnt_r == 6'(TOT_W - 1)) state_nxt = S_BUILD;
      end
      S_BUILD: begin
        if (cnt_full > 37'(MAX_SEGMENTS)) begin
          status_nxt = ST_MAP_FAIL;
          state_nxt  = S_DONE;
        end else begin
          map_valid_nxt    = 1'b1;
          mapped_size_nxt  = seg_r;
          tail_size_nxt    = (rem_r != 16'd0) ? rem_r : seg_r;
          map_count_nxt    = cnt_full[CNT_W-1:0];
          empty_total_nxt  = cnt_full[CNT_W-1:0];
          resend_total_nxt = '0;
          addr_nxt         = '0;
          clr_ins_nxt      = 1'b1;
          state_nxt        = S_CLEAR;
        end
      end
      S_INS_RD: begin
        mem_raddr = idx;
        woff_nxt  = 35'(idx) * 35'(mapped_size_r);
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        state_nxt = S_DONE;
        if (seg_r != size_sel && seg_r != mapped_size_r) begin
          status_nxt = ST_SIZE;
          woff_nxt   = '0;
        end else if (mem_rdata_r == MARK_FILLED) begin
          status_nxt = ST_DUP;
          woff_nxt   = '0;
        end else begin
          wlen_nxt  = size_sel;
          mem_we    = 1'b1;
          mem_waddr = idx;
          mem_wdata = MARK_FILLED;
          if (empty_total_r != '0) empty_total_nxt = empty_total_r - 1'b1;
        end
      end
      S_RES: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = MARK_ASKED;
        addr_nxt  = addr_r + 1'b1;
        if (addr_r == SEG_AW'(stop_r - 24'd1)) begin
          resend_total_nxt = (resend_sum > 25'hFFFFFF) ? 24'hFFFFFF : resend_sum[23:0];
          state_nxt        = S_DONE;
        end
      end
      S_RUN_RD: begin
        mem_raddr = SEG_AW'(walk_r - 1'b1);
        state_nxt = (walk_r == '0) ? S_DONE : S_RUN_CHK;
      end
      S_RUN_CHK: begin
        if (mem_rdata_r == MARK_EMPTY) begin
          run_nxt   = run_r + 1'b1;
          walk_nxt  = walk_r - 1'b1;
          state_nxt = S_RUN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = status_r;
          o_woff_nxt    = woff_r;
          o_wlen_nxt    = wlen_r;
          o_run_nxt     = run_r;
          o_empty_nxt   = empty_total_r;
          o_resend_nxt  = resend_total_r;
          o_count_nxt   = cnt_eff;
          o_leader_nxt  = leader_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_write_offset    = o_woff_r;
  assign out_write_length    = o_wlen_r;
  assign out_empty_run       = o_run_r;
  assign out_segments_empty  = o_empty_r;
  assign out_resend_requests = o_resend_r;
  assign out_segment_count   = o_count_r;
  assign out_leader_done     = o_leader_r;

  `SSRT_ASSERT_NXT(a_accept_disp, in_valid && in_ready, state_r == S_DISP)
  `SSRT_ASSERT_IMP(a_empty_le_count, map_valid_r, empty_total_r <= map_count_r)
  `SSRT_ASSERT_IMP(a_count_range, map_valid_r,
                   map_count_r != '0 && map_count_r <= CNT_W'(MAX_SEGMENTS))
  `SSRT_ASSERT_IMP(a_res_mapped, state_r == S_RES, map_valid_r)
endmodule

// File: tb/sv/stream_segment_reassembly_tracker_test.sv
// testbench for the segment reassembly tracker: random phases, predicting scoreboard
`timescale 1ns / 1ps
module stream_segment_reassembly_tracker_test;
  import ssrt_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [34:0] write_offset;
    logic [15:0] write_length;
    logic [13:0] empty_run;
    logic [13:0] segments_empty;
    logic [23:0] resend_requests;
    logic [13:0] segment_count;
    logic        leader_done;
  } frame_result_t;

  class reassembly_scoreboard;
    logic [15:0]   width_r, height_r;
    logic [6:0]    bpp_r;
    mark_t         marks [MAX_SEGMENTS];
    bit            map_ok;
    int unsigned   seg_size, tail_sz, map_count, empty_total, resend_total;
    bit            leader;
    frame_result_t expected_q[$];
    int            errors;

    function new();
      width_r = 0;
      height_r = 0;
      bpp_r = 8;
      foreach (marks[i]) marks[i] = MARK_EMPTY;
      map_ok = 0;
      seg_size = 0;
      tail_sz = 0;
      map_count = 0;
      empty_total = 0;
      resend_total = 0;
      leader = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == REG_WIDTH && width_r != data) begin
        width_r = data;
        map_ok = 0;
      end else if (idx == REG_HEIGHT && height_r != data) begin
        height_r = data;
        map_ok = 0;
      end else if (idx == REG_BPP && bpp_r != data[6:0]) begin
        bpp_r = data[6:0];
        map_ok = 0;
      end
    endfunction

    function bit build_map(int unsigned seg);
      longint unsigned total, rem, cnt;
      total = (longint'(width_r) * longint'(height_r) * longint'(bpp_r)) / 8;
      if (seg == 0 || total == 0) return 0;
      rem = total % seg;
      cnt = total / seg + (rem != 0 ? 1 : 0);
      if (cnt > MAX_SEGMENTS) return 0;
      foreach (marks[i]) marks[i] = MARK_EMPTY;
      map_ok = 1;
      seg_size = seg;
      tail_sz = rem != 0 ? int'(rem) : seg;
      map_count = int'(cnt);
      empty_total = int'(cnt);
      resend_total = 0;
      return 1;
    endfunction

    function int unsigned live_count();
      return map_ok ? map_count : 0;
    endfunction

    function void note_input(mode_t m, int unsigned id, int unsigned stop, int unsigned seg);
      frame_result_t r;
      int unsigned   sz, i, run;
      longint unsigned sum;
      r = '0;
      r.status = ST_OK;
      run = 0;
      case (m)
        MODE_INSERT: begin
          if (id == 0) r.status = ST_ID_ZERO;
          else if (!map_ok && !build_map(seg)) r.status = ST_MAP_FAIL;
          else if (id > map_count) r.status = ST_ID_RANGE;
          else begin
            sz = (id == map_count) ? tail_sz : seg_size;
            if (seg != sz && seg != seg_size) r.status = ST_SIZE;
            else if (marks[id-1] == MARK_FILLED) r.status = ST_DUP;
            else begin
              r.write_offset = 35'(longint'(id - 1) * seg_size);
              r.write_length = 16'(sz);
              marks[id-1] = MARK_FILLED;
              if (empty_total > 0) empty_total--;
            end
          end
        end
        MODE_RESEND: begin
          if (!map_ok || id == 0 || stop < id || stop > map_count) r.status = ST_BAD_RANGE;
          else begin
            for (i = id - 1; i < stop; i++) marks[i] = MARK_ASKED;
            sum = longint'(resend_total) + stop - id + 1;
            resend_total = sum > 24'hFFFFFF ? 24'hFFFFFF : int'(sum);
          end
        end
        MODE_RUN: begin
          if (id >= 2) begin
            if (id > live_count() + 1) r.status = ST_ID_RANGE;
            else begin
              i = id - 1;
              while (i > 0 && marks[i-1] == MARK_EMPTY) begin
                run++;
                i--;
              end
            end
          end
        end
        default: leader = 1;
      endcase
      r.empty_run = 14'(run);
      r.segments_empty = 14'(empty_total);
      r.resend_requests = 24'(resend_total);
      r.segment_count = 14'(live_count());
      r.leader_done = leader;
      expected_q.push_back(r);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t e;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status != e.status) begin
        $error("status exp %0d got %0d", e.status, got.status);
        errors++;
      end
      if (got.write_offset != e.write_offset) begin
        $error("write_offset exp %0d got %0d", e.write_offset, got.write_offset);
        errors++;
      end
      if (got.write_length != e.write_length) begin
        $error("write_length exp %0d got %0d", e.write_length, got.write_length);
        errors++;
      end
      if (got.empty_run != e.empty_run) begin
        $error("empty_run exp %0d got %0d", e.empty_run, got.empty_run);
        errors++;
      end
      if (got.segments_empty != e.segments_empty) begin
        $error("segments_empty exp %0d got %0d", e.segments_empty, got.segments_empty);
        errors++;
      end
      if (got.resend_requests != e.resend_requests) begin
        $error("resend_requests exp %0d got %0d", e.resend_requests, got.resend_requests);
        errors++;
      end
      if (got.segment_count != e.segment_count) begin
        $error("segment_count exp %0d got %0d", e.segment_count, got.segment_count);
        errors++;
      end
      if (got.leader_done != e.leader_done) begin
        $error("leader_done exp %0d got %0d", e.leader_done, got.leader_done);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [1:0]  in_mode;
  logic [23:0] in_packet_id, in_stop_id;
  logic [15:0] in_segment_bytes;
  logic        out_valid, out_ready;
  logic [2:0]  out_status;
  logic [34:0] out_write_offset;
  logic [15:0] out_write_length;
  logic [13:0] out_empty_run, out_segments_empty, out_segment_count;
  logic [23:0] out_resend_requests;
  logic        out_leader_done;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  reassembly_scoreboard sb;
  int in_quiet, out_quiet, results_seen, idle_cycles;

  stream_segment_reassembly_tracker dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_mode = MODE_INSERT;
    in_packet_id = 0;
    in_stop_id = 0;
    in_segment_bytes = 0;
    out_ready = 0;
    cfg_valid = 0;
    cfg_index = REG_WIDTH;
    cfg_data = 0;
    results_seen = 0;
    in_quiet = 0;
    out_quiet = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("FAIL stream_segment_reassembly_tracker");
      $finish;
    end
  end

  // result side
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (out_quiet > 0) begin
        out_quiet--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 24) == 0) out_quiet = $urandom_range(10, 40);
      end
      if (results_seen == 150) gap = 400;
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result({status_t'(out_status), out_write_offset, out_write_length,
                       out_empty_run, out_segments_empty, out_resend_requests,
                       out_segment_count, out_leader_done});
      results_seen++;
    end
  end

  task automatic send_word(mode_t m, int unsigned id, int unsigned stop, int unsigned seg);
    int gap;
    logic [23:0] id_w, stop_w;
    logic [15:0] seg_w;
    id_w = id[23:0];
    stop_w = stop[23:0];
    seg_w = seg[15:0];
    if (in_quiet > 0) begin
      in_quiet--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 24) == 0) in_quiet = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_mode <= m;
    in_packet_id <= id_w;
    in_stop_id <= stop_w;
    in_segment_bytes <= seg_w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(m, id_w, stop_w, seg_w);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned bpp);
    write_cfg(REG_WIDTH, 16'(w));
    write_cfg(REG_HEIGHT, 16'(h));
    write_cfg(REG_BPP, 16'(bpp));
  endtask

  task automatic random_word();
    int unsigned cnt, id, lo, hi, pick;
    cnt = sb.live_count();
    pick = $urandom_range(0, 99);
    if (cnt == 0 || pick < 8) begin
      send_word(mode_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
    end else if (pick < 65) begin
      id = $urandom_range(1, cnt);
      if (pick < 60)
        send_word(MODE_INSERT, id, $urandom,
                  (id == cnt && pick % 4 != 0) ? sb.tail_sz : sb.seg_size);
      else send_word(MODE_INSERT, $urandom_range(0, cnt + 1), 0, $urandom_range(0, 70));
    end else if (pick < 78) begin
      lo = $urandom_range(1, cnt);
      hi = lo + $urandom_range(0, 8);
      if (hi > cnt && pick % 3 != 0) hi = cnt;
      send_word(MODE_RESEND, lo, hi, $urandom);
    end else if (pick < 96) begin
      send_word(MODE_RUN, $urandom_range(0, cnt + 2), $urandom, $urandom);
    end else begin
      send_word(MODE_LEADER, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned w, h, bpp, frame, seg;
    @(posedge rst_n);
    @(posedge clk);

    // directed: empty frame, then a 40 byte frame in three segments
    send_word(MODE_INSERT, 1, 0, 16);
    send_word(MODE_RUN, 1, 0, 0);
    send_word(MODE_RESEND, 1, 1, 0);
    set_frame(10, 4, 8);
    send_word(MODE_INSERT, 0, 0, 16);
    send_word(MODE_INSERT, 1, 0, 0);
    send_word(MODE_INSERT, 1, 0, 16);
    send_word(MODE_INSERT, 3, 0, 8);
    send_word(MODE_INSERT, 3, 0, 16);
    send_word(MODE_INSERT, 2, 0, 5);
    send_word(MODE_INSERT, 4, 0, 16);
    send_word(MODE_INSERT, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
    send_word(MODE_RUN, 0, 0, 0);
    send_word(MODE_RUN, 3, 0, 0);
    send_word(MODE_RUN, 5, 0, 0);
    send_word(MODE_RESEND, 0, 2, 0);
    send_word(MODE_RESEND, 3, 2, 0);
    send_word(MODE_RESEND, 1, 4, 0);
    send_word(MODE_RESEND, 1, 3, 0);
    send_word(MODE_INSERT, 1, 0, 16);
    send_word(MODE_RUN, 4, 0, 0);
    send_word(MODE_LEADER, 0, 0, 0);
    write_cfg(REG_BPP, 8);
    send_word(MODE_INSERT, 2, 0, 16);

    // largest settings: the map cannot be built
    set_frame(16'hFFFF, 16'hFFFF, 64);
    send_word(MODE_INSERT, 1, 0, 16'hFFFF);
    send_word(MODE_RUN, 2, 0, 0);
    // a full map of the largest segment count
    set_frame(8192, 1, 8);
    send_word(MODE_INSERT, 8192, 0, 1);
    send_word(MODE_RUN, 8192, 0, 0);
    send_word(MODE_RUN, 8193, 0, 0);
    send_word(MODE_RESEND, 1, 8192, 0);
    send_word(MODE_INSERT, 8192, 0, 1);
    set_frame(8193, 1, 8);
    send_word(MODE_INSERT, 1, 0, 1);
    set_frame(3, 5, 1);
    send_word(MODE_INSERT, 1, 0, 1);

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 4) drain();
      w = $urandom_range(1, 64);
      h = $urandom_range(1, 16);
      bpp = (ph == 2) ? 64 : (ph == 5) ? 1 : $urandom_range(1, 64);
      if (ph == 7) w = 0;
      set_frame(w, h, bpp);
      frame = w * h * bpp / 8;
      seg = frame / $urandom_range(1, 40);
      if (seg == 0) seg = 1;
      send_word(MODE_INSERT, 1, 0, seg);
      repeat (100) random_word();
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("PASS stream_segment_reassembly_tracker");
    else $display("FAIL stream_segment_reassembly_tracker");
    $finish;
  end
endmodule
